>>> hw/rtl/pfwtt_pkg.sv
// Shared types, operation codes and defaults for the page first-writer trace table.
package pfwtt_pkg;

  localparam int PHYS_W            = 29;
  localparam int DEF_TABLE_DEPTH   = 4096;
  localparam int DEF_PAGE_BYTES    = 4096;
  localparam int DEF_MAX_FRAMES    = 32;
  localparam logic [PHYS_W-1:0] MAX_SPAN_RESET = 29'd16777216;

  localparam logic CFG_ENABLED  = 1'b0;
  localparam logic CFG_MAX_SPAN = 1'b1;

  typedef enum logic [2:0] {
    REQ_NOTE   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_REARM  = 3'd2,
    REQ_LOOKUP = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_code_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_NOTE,
    OP_WRITE,
    OP_REARM,
    OP_LOOKUP,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] address;
    logic [28:0] length;
    logic [31:0] writer_tag;
    logic [5:0]  frame_count;
  } req_t;

  typedef struct packed {
    logic        found;
    logic        found_in_previous;
    logic [31:0] found_writer;
    logic [5:0]  found_frames;
    logic        watch_valid;
    logic [28:0] watch_base;
    logic [29:0] watch_length;
    logic        accepted;
    logic [17:0] pages_added;
    logic [31:0] buffers_seen;
    logic [31:0] samples_taken;
  } res_t;

  typedef struct packed {
    op_t         op;
    logic [28:0] phys;
    logic [30:0] last_addr;
    logic [31:0] writer;
    logic [5:0]  frames;
  } cmd_t;

endpackage

>>> hw/rtl/pfwtt_front.sv
// Front end: takes a request, masks and saturates its fields and classifies it.
module pfwtt_front import pfwtt_pkg::*; #(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES,
  parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  req_t request,
  input  logic enabled,
  input  logic q_ready,
  output logic cmd_valid,
  output cmd_t cmd
);

  localparam int SH = $clog2(PAGE_BYTES);

  logic [28:0] phys;
  logic [28:0] len;
  logic [28:0] len_m1;
  logic [30:0] end_addr;
  logic [5:0]  frames;
  op_t         op;

  always_comb begin
    phys     = request.address[28:0];
    len      = request.length;
    len_m1   = (len != '0) ? len - 29'd1 : '0;
    end_addr = {2'b00, phys} + {2'b00, len_m1};
    if ({1'b0, request.frame_count} > 7'(MAX_FRAMES)) begin
      frames = 6'(MAX_FRAMES);
    end else begin
      frames = request.frame_count;
    end
    op = OP_NOP;
    if (enabled) begin
      case (request.req_type)
        REQ_NOTE:   op = (len != '0) ? OP_NOTE : OP_NOP;
        REQ_WRITE:  op = (frames != '0) ? OP_WRITE : OP_NOP;
        REQ_REARM:  op = OP_REARM;
        REQ_LOOKUP: op = OP_LOOKUP;
        REQ_CLEAR:  op = OP_CLEAR;
        default:    op = OP_NOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid     <= 1'b1;
      cmd.op        <= op;
      cmd.phys      <= phys;
      cmd.last_addr <= {end_addr[30:SH], SH'(0)};
      cmd.writer    <= request.writer_tag;
      cmd.frames    <= frames;
    end else if (cmd_valid && q_ready) begin
      cmd_valid <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/pfwtt_queue.sv
// Two-entry command queue between the front end and the back end.
module pfwtt_queue import pfwtt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic ready,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && ready) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push && ready) - 2'(pop && valid);
    end
  end

endmodule

>>> hw/rtl/pfwtt_back.sv
// Back end: span state, counters, slot index and the two table generations.
module pfwtt_back import pfwtt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int PAGE_BYTES  = DEF_PAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  cmd_t        cmd_in,
  output logic        cmd_pop,
  input  logic [28:0] max_span,
  input  logic        clear_req,
  output logic        active,
  output logic        result_valid,
  output res_t        result
);

  localparam int SH         = $clog2(PAGE_BYTES);
  localparam int PN_W       = PHYS_W - SH;
  localparam int PAGE_COUNT = 2 ** PN_W;
  localparam int TAB_AW     = $clog2(TABLE_DEPTH);
  localparam int FILL_W     = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W      = PN_W + 38;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_W_ISSUE, S_W_SLOT, S_W_TAB,
    S_L_ISSUE, S_L_SLOT, S_L_TAB, S_L_PSLOT, S_L_PTAB
  } state_t;

  state_t            state;
  cmd_t              cmd;
  logic              bank;
  logic [FILL_W-1:0] cur_fill;
  logic [FILL_W-1:0] prev_fill;
  logic [31:0]       span_first;
  logic [31:0]       span_last;
  logic [31:0]       buf_cnt;
  logic [31:0]       smp_cnt;
  logic [PN_W:0]     page_pn;
  logic [17:0]       added;
  logic [FILL_W-1:0] slot_s;
  logic [PN_W:0]     init_addr;

  logic [FILL_W-1:0] slot_mem [2*PAGE_COUNT];
  logic [ENT_W-1:0]  tab_mem  [2*TABLE_DEPTH];
  logic [FILL_W-1:0] slot_q;
  logic [ENT_W-1:0]  tab_q;

  logic              rd_bank;
  logic [PN_W-1:0]   rd_pn;
  logic [PN_W:0]     slot_raddr;
  logic [FILL_W-1:0] slot_sel;
  logic [FILL_W-1:0] slot_m1;
  logic [TAB_AW:0]   tab_raddr;
  logic              wr_en;

  logic [PN_W-1:0]   cmd_pn;
  logic [PN_W+1:0]   last_hi;
  logic [PN_W:0]     wlast_pn;
  logic              empty;
  logic              known;
  logic [31:0]       first32;
  logic [31:0]       last32;
  logic [31:0]       gf;
  logic [31:0]       gl;
  logic              cur_hit;
  logic              prev_hit;
  logic [PN_W-1:0]   tab_page;

  always_comb begin
    cmd_pn   = cmd.phys[28:SH];
    last_hi  = cmd.last_addr[30:SH];
    wlast_pn = (last_hi > (PN_W+2)'(PAGE_COUNT - 1)) ? {1'b0, {PN_W{1'b1}}}
                                                     : last_hi[PN_W:0];
    empty    = span_last < span_first;
    known    = !empty && ({3'b000, cmd.phys} >= span_first)
                      && ({3'b000, cmd.phys} <= span_last);
    first32  = {3'b000, cmd.phys[28:SH], SH'(0)};
    last32   = {1'b0, cmd.last_addr};
    gf = (empty || first32 < span_first) ? first32 : span_first;
    gl = (empty || last32 > span_last) ? last32 : span_last;

    rd_bank  = (state == S_L_TAB || state == S_L_PSLOT) ? ~bank : bank;
    rd_pn    = (state == S_W_ISSUE) ? page_pn[PN_W-1:0] : cmd_pn;
    slot_raddr = {rd_bank, rd_pn};
    slot_sel = (state == S_W_SLOT || state == S_L_SLOT || state == S_L_PSLOT) ? slot_q : slot_s;
    slot_m1  = slot_sel - FILL_W'(1);
    tab_raddr = {rd_bank, slot_m1[TAB_AW-1:0]};

    tab_page = tab_q[ENT_W-1 -: PN_W];
    cur_hit  = (slot_s != '0) && (slot_s <= cur_fill) && (tab_page == rd_pn);
    prev_hit = (slot_s != '0) && (slot_s <= prev_fill) && (tab_page == cmd_pn);
    wr_en    = (state == S_W_TAB) && !((slot_s != '0) && (slot_s <= cur_fill)
                                      && (tab_page == page_pn[PN_W-1:0]));
  end

  assign cmd_pop = (state == S_IDLE) && cmd_valid;
  assign active  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (state == S_INIT) begin
      slot_mem[init_addr] <= '0;
    end else if (wr_en) begin
      slot_mem[{bank, page_pn[PN_W-1:0]}] <= cur_fill + FILL_W'(1);
    end
    slot_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tab_mem[{bank, cur_fill[TAB_AW-1:0]}] <= {page_pn[PN_W-1:0], cmd.writer, cmd.frames};
    end
    tab_q <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      init_addr    <= '0;
      result_valid <= 1'b0;
      bank         <= 1'b0;
      cur_fill     <= '0;
      prev_fill    <= '0;
      span_first   <= '1;
      span_last    <= '0;
      buf_cnt      <= '0;
      smp_cnt      <= '0;
    end else begin
      result_valid <= 1'b0;
      if (clear_req) begin
        bank       <= 1'b0;
        cur_fill   <= '0;
        prev_fill  <= '0;
        span_first <= '1;
        span_last  <= '0;
        buf_cnt    <= '0;
        smp_cnt    <= '0;
      end
      case (state)
        S_INIT: begin
          init_addr <= init_addr + (PN_W+1)'(1);
          if (init_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cmd   <= cmd_in;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          result               <= '0;
          result.buffers_seen  <= buf_cnt;
          result.samples_taken <= smp_cnt;
          result_valid         <= 1'b1;
          state                <= S_IDLE;
          case (cmd.op)
            OP_NOTE: begin
              if (gl - gf <= {3'b000, max_span}) begin
                span_first          <= gf;
                span_last           <= gl;
                buf_cnt             <= buf_cnt + 32'd1;
                result.buffers_seen <= buf_cnt + 32'd1;
                result.accepted     <= 1'b1;
              end
            end
            OP_WRITE: begin
              if (known && cur_fill < FILL_W'(TABLE_DEPTH)) begin
                result.accepted <= 1'b1;
                page_pn         <= {1'b0, cmd_pn};
                added           <= '0;
                result_valid    <= 1'b0;
                state           <= S_W_ISSUE;
              end
            end
            OP_REARM: begin
              prev_fill <= cur_fill;
              cur_fill  <= '0;
              bank      <= ~bank;
              if (!empty) begin
                result.watch_valid  <= 1'b1;
                result.watch_base   <= span_first[28:0];
                result.watch_length <= 30'(span_last - span_first + 32'(PAGE_BYTES));
              end
            end
            OP_LOOKUP: begin
              result_valid <= 1'b0;
              state        <= S_L_ISSUE;
            end
            OP_CLEAR: begin
              bank                 <= 1'b0;
              cur_fill             <= '0;
              prev_fill            <= '0;
              span_first           <= '1;
              span_last            <= '0;
              buf_cnt              <= '0;
              smp_cnt              <= '0;
              result.buffers_seen  <= '0;
              result.samples_taken <= '0;
            end
            default: begin
            end
          endcase
        end
        S_W_ISSUE: begin
          if (page_pn <= wlast_pn && cur_fill < FILL_W'(TABLE_DEPTH)) begin
            state <= S_W_SLOT;
          end else begin
            result.pages_added   <= added;
            result.samples_taken <= smp_cnt;
            result_valid         <= 1'b1;
            state                <= S_IDLE;
          end
        end
        S_W_SLOT: begin
          slot_s <= slot_q;
          state  <= S_W_TAB;
        end
        S_W_TAB: begin
          if (wr_en) begin
            cur_fill <= cur_fill + FILL_W'(1);
            smp_cnt  <= smp_cnt + 32'd1;
            added    <= added + 18'd1;
          end
          page_pn <= page_pn + (PN_W+1)'(1);
          state   <= S_W_ISSUE;
        end
        S_L_ISSUE: state <= S_L_SLOT;
        S_L_SLOT: begin
          slot_s <= slot_q;
          state  <= S_L_TAB;
        end
        S_L_TAB: begin
          if (cur_hit) begin
            result.found        <= 1'b1;
            result.found_writer <= tab_q[37:6];
            result.found_frames <= tab_q[5:0];
            result_valid        <= 1'b1;
            state               <= S_IDLE;
          end else begin
            state <= S_L_PSLOT;
          end
        end
        S_L_PSLOT: begin
          slot_s <= slot_q;
          state  <= S_L_PTAB;
        end
        S_L_PTAB: begin
          if (prev_hit) begin
            result.found             <= 1'b1;
            result.found_in_previous <= 1'b1;
            result.found_writer      <= tab_q[37:6];
            result.found_frames      <= tab_q[5:0];
          end
          result_valid <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    cur_fill <= FILL_W'(TABLE_DEPTH) && prev_fill <= FILL_W'(TABLE_DEPTH))
    else $error("table fill beyond depth");

  a_result_ends_work: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> state == S_IDLE)
    else $error("result shown while work continues");

  a_insert_grows_fill: assert property (@(posedge clk) disable iff (rst)
    wr_en && !clear_req |=> cur_fill == $past(cur_fill) + FILL_W'(1))
    else $error("insert did not advance fill");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> state == S_DISPATCH)
    else $error("command popped without dispatch");

endmodule

>>> hw/rtl/page_first_writer_trace_table_core.sv
// Top level: configuration registers, handshake and the front, queue and back ends.
// One transaction at a time; busy rises the cycle after start is taken.
// Note buffer, rearm, clear and ignored requests give their result from the dispatch state;
// a lookup searches the current generation first, then the previous.
// A guest write walks its pages one at a time, each by slot read, table read, possible insert.
// Synchronous reset clears span, counters and fills, then zeroes every slot index entry in both banks.
module page_first_writer_trace_table_core import pfwtt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int PAGE_BYTES  = DEF_PAGE_BYTES,
  parameter int MAX_FRAMES  = DEF_MAX_FRAMES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        request,
  output logic        result_valid,
  output res_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [28:0] cfg_data
);

  logic        enabled;
  logic [28:0] max_span;
  logic        accept;
  logic        clear_req;
  logic        f_valid;
  cmd_t        f_cmd;
  logic        q_ready;
  logic        q_valid;
  cmd_t        q_head;
  logic        q_pop;
  logic        b_active;

  assign busy      = f_valid || q_valid || b_active;
  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign clear_req = cfg_valid && cfg_ready && (cfg_index == CFG_ENABLED)
                     && enabled && !cfg_data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled  <= 1'b0;
      max_span <= MAX_SPAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLED:  enabled  <= cfg_data[0];
        CFG_MAX_SPAN: max_span <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pfwtt_front #(
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .request   (request),
    .enabled   (enabled),
    .q_ready   (q_ready),
    .cmd_valid (f_valid),
    .cmd       (f_cmd)
  );

  pfwtt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_valid),
    .push_cmd (f_cmd),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  pfwtt_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (q_valid),
    .cmd_in       (q_head),
    .cmd_pop      (q_pop),
    .max_span     (max_span),
    .clear_req    (clear_req),
    .active       (b_active),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
